/* hw/rtl/periodic_oneshot_timer_table_defines.svh */
// ---------------------------------------------------------------------------
// periodic_oneshot_timer_table_defines.svh
// Assertion macros for the timer table. Define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
// check gated off while reset is asserted
`define POTT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that holds in and out of reset
`define POTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define POTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define POTT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/pott_pkg.sv */
// ---------------------------------------------------------------------------
// pott_pkg
// Shared codes, types and defaults of the timer table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pott_pkg;

  localparam int SLOTS_DEF = 16;

  // operation codes
  localparam logic [2:0] OP_REG_PER = 3'd0;
  localparam logic [2:0] OP_REG_ONE = 3'd1;
  localparam logic [2:0] OP_CANCEL  = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_REG    = 3'd0;
  localparam logic [2:0] KIND_CANCEL = 3'd1;
  localparam logic [2:0] KIND_FIRE   = 3'd2;
  localparam logic [2:0] KIND_SCAN   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // what the output register loads
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_DONE,
    EMIT_REG,
    EMIT_CANCEL,
    EMIT_FIRE
  } emit_t;

  typedef struct packed {
    logic        periodic;
    logic [31:0] task_id;
    logic [31:0] period;
    logic [63:0] due;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic  load;
    logic  clear_all;
    logic  do_reg;
    logic  idx_clr;
    logic  idx_inc;
    logic  rd_en;
    logic  set_cancel;
    logic  free_slot;
    logic  adv_due;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       refuse_reg;
    logic       full;
    logic       cid_zero;
    logic       cur_valid;
    logic       cur_cancelled;
    logic       id_match;
    logic       due_hit;
    logic       rd_periodic;
    logic       idx_last;
    logic       out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/pott_in_if.sv */
// ---------------------------------------------------------------------------
// pott_in_if
// Request channel into the timer table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pott_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] amount_us;
  logic [31:0] cancel_id;
  logic [63:0] now_us;

  modport source (output valid, op, amount_us, cancel_id, now_us, input ready);
  modport sink   (input valid, op, amount_us, cancel_id, now_us, output ready);
endinterface

/* hw/rtl/pott_out_if.sv */
// ---------------------------------------------------------------------------
// pott_out_if
// Result channel out of the timer table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pott_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] result_id;
  logic        ok;
  logic        last;

  modport source (output valid, kind, result_id, ok, last, input ready);
  modport sink   (input valid, kind, result_id, ok, last, output ready);
endinterface

/* hw/rtl/pott_ram.sv */
// ---------------------------------------------------------------------------
// pott_ram
// Generic one-write one-read RAM, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pott_ctrl.sv */
// ---------------------------------------------------------------------------
// pott_ctrl
// Sequencer: dispatches one request, walks the slots, issues commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pott_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pott_pkg::dp_stat_t  stat,
  output pott_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_C_RD = 3'd2;
  localparam logic [2:0] S_C_EV = 3'd3;
  localparam logic [2:0] S_T_RD = 3'd4;
  localparam logic [2:0] S_T_EV = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.emit  = pott_pkg::EMIT_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op)
          pott_pkg::OP_REG_PER, pott_pkg::OP_REG_ONE: begin
            if (stat.refuse_reg) begin
              state_nxt = S_FIN;
            end else if (stat.out_free) begin
              cmd.do_reg = 1'b1;
              cmd.emit   = pott_pkg::EMIT_REG;
              state_nxt  = S_IDLE;
            end
          end
          pott_pkg::OP_CANCEL: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = stat.cid_zero ? S_FIN : S_C_RD;
          end
          pott_pkg::OP_TICK: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_T_RD;
          end
          pott_pkg::OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_nxt     = S_FIN;
          end
          default: state_nxt = S_IDLE;  // unused op: no result
        endcase
      end
      S_C_RD: begin
        if (stat.cur_valid && !stat.cur_cancelled) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_C_EV;
        end else if (stat.idx_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_C_EV: begin
        if (stat.id_match) begin
          if (stat.out_free) begin
            cmd.set_cancel = 1'b1;
            cmd.emit       = pott_pkg::EMIT_CANCEL;
            state_nxt      = S_IDLE;
          end
        end else if (stat.idx_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_C_RD;
        end
      end
      S_T_RD: begin
        if (stat.cur_valid && !stat.cur_cancelled) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_T_EV;
        end else begin
          cmd.free_slot = stat.cur_valid;  // cancelled slot is dropped
          if (stat.idx_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_T_EV: begin
        if (!stat.due_hit || stat.out_free) begin
          if (stat.due_hit) begin
            cmd.emit      = pott_pkg::EMIT_FIRE;
            cmd.adv_due   = stat.rd_periodic;
            cmd.free_slot = !stat.rd_periodic;
          end
          if (stat.idx_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_T_RD;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = pott_pkg::EMIT_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/pott_dp.sv */
// ---------------------------------------------------------------------------
// pott_dp
// Datapath: request latch, slot flags, slot store, id counter, result reg.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pott_dp #(
  parameter int SLOTS = pott_pkg::SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pott_pkg::ctrl_cmd_t cmd,
  output pott_pkg::dp_stat_t  stat,
  input  logic [2:0]          in_op,
  input  logic [31:0]         in_amount_us,
  input  logic [31:0]         in_cancel_id,
  input  logic [63:0]         in_now_us,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [31:0]         out_result_id,
  output logic                out_ok,
  output logic                out_last
);

  logic [2:0]  op_r;
  logic [31:0] amount_r;
  logic [31:0] cid_r;
  logic [63:0] now_r;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] canc_r, canc_nxt;
  logic [31:0]      next_id_r, next_id_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    free_idx;

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [31:0] out_id_r;
  logic        out_ok_r;
  logic        out_last_r;

  pott_pkg::slot_entry_t rd_entry, new_entry, adv_entry, wr_entry;
  logic [pott_pkg::ENTRY_W-1:0] rd_word;
  logic [IW-1:0]                waddr;
  logic                         we;
  logic                         out_free;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign rd_entry = pott_pkg::slot_entry_t'(rd_word);

  always_comb begin
    new_entry.periodic = (op_r == pott_pkg::OP_REG_PER);
    new_entry.task_id  = next_id_r;
    new_entry.period   = new_entry.periodic ? amount_r : 32'd0;
    new_entry.due      = now_r + {32'd0, amount_r};
    adv_entry          = rd_entry;
    adv_entry.due      = rd_entry.due + {32'd0, rd_entry.period};
  end

  assign we       = cmd.do_reg | cmd.adv_due;
  assign waddr    = cmd.do_reg ? free_idx : idx_r;
  assign wr_entry = cmd.do_reg ? new_entry : adv_entry;

  pott_ram #(
    .WIDTH (pott_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (rd_word)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.op            = op_r;
    stat.full          = &valid_r;
    stat.refuse_reg    = ((op_r == pott_pkg::OP_REG_PER) && (amount_r == 32'd0)) || (&valid_r);
    stat.cid_zero      = (cid_r == 32'd0);
    stat.cur_valid     = valid_r[idx_r];
    stat.cur_cancelled = canc_r[idx_r];
    stat.id_match      = (rd_entry.task_id == cid_r);
    stat.due_hit       = (now_r >= rd_entry.due);
    stat.rd_periodic   = rd_entry.periodic;
    stat.idx_last      = (idx_r == IW'(SLOTS - 1));
    stat.out_free      = out_free;
  end

  // flags, id counter, slot index
  always_comb begin
    valid_nxt   = valid_r;
    canc_nxt    = canc_r;
    next_id_nxt = next_id_r;
    idx_nxt     = idx_r;
    if (cmd.clear_all) begin
      valid_nxt = '0;
      canc_nxt  = '0;
    end
    if (cmd.do_reg) begin
      valid_nxt[free_idx] = 1'b1;
      canc_nxt[free_idx]  = 1'b0;
      next_id_nxt         = next_id_r + 32'd1;
      if (next_id_nxt == 32'd0) begin
        next_id_nxt = 32'd1;  // ids skip zero on wrap
      end
    end
    if (cmd.set_cancel) begin
      canc_nxt[idx_r] = 1'b1;
    end
    if (cmd.free_slot) begin
      valid_nxt[idx_r] = 1'b0;
      canc_nxt[idx_r]  = 1'b0;
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      canc_r    <= '0;
      next_id_r <= 32'd1;
      idx_r     <= '0;
    end else begin
      valid_r   <= valid_nxt;
      canc_r    <= canc_nxt;
      next_id_r <= next_id_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      amount_r <= in_amount_us;
      cid_r    <= in_cancel_id;
      now_r    <= in_now_us;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != pott_pkg::EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      pott_pkg::EMIT_NONE: begin
      end
      pott_pkg::EMIT_DONE: begin
        unique case (op_r)
          pott_pkg::OP_REG_PER, pott_pkg::OP_REG_ONE: out_kind_r <= pott_pkg::KIND_REG;
          pott_pkg::OP_CANCEL: out_kind_r <= pott_pkg::KIND_CANCEL;
          pott_pkg::OP_TICK:   out_kind_r <= pott_pkg::KIND_SCAN;
          default:             out_kind_r <= pott_pkg::KIND_CLEAR;
        endcase
        out_id_r   <= 32'd0;
        out_ok_r   <= 1'b0;
        out_last_r <= 1'b1;
      end
      pott_pkg::EMIT_REG: begin
        out_kind_r <= pott_pkg::KIND_REG;
        out_id_r   <= next_id_r;
        out_ok_r   <= 1'b1;
        out_last_r <= 1'b1;
      end
      pott_pkg::EMIT_CANCEL: begin
        out_kind_r <= pott_pkg::KIND_CANCEL;
        out_id_r   <= cid_r;
        out_ok_r   <= 1'b1;
        out_last_r <= 1'b1;
      end
      pott_pkg::EMIT_FIRE: begin
        out_kind_r <= pott_pkg::KIND_FIRE;
        out_id_r   <= rd_entry.task_id;
        out_ok_r   <= 1'b0;
        out_last_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_result_id = out_id_r;
  assign out_ok        = out_ok_r;
  assign out_last      = out_last_r;

endmodule

/* hw/rtl/periodic_oneshot_timer_table.sv */
// Flow: a registration is written to a free slot and its result loaded after dispatch (a
// refused one gives a done result); a cancel reads each live slot and then checks its id, with
// a done result when nothing matches; a tick reads and then evaluates each live slot, drops
// cancelled ones, and ends in a scan-done result. One request at a time: the next is taken only
// once this one is through, including the read-then-evaluate walk of the slot store.
// Reset (synchronous, rst_n low): sequencer idle, table empty, next id 1, result register
// empty; the slot store itself is not cleared, so the block is ready right after reset.
// ---------------------------------------------------------------------------
// periodic_oneshot_timer_table
// Table of periodic and one-shot timer slots with register, cancel, tick
// scan and clear requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_oneshot_timer_table_defines.svh"

module periodic_oneshot_timer_table #(
  parameter int SLOTS = pott_pkg::SLOTS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  pott_in_if.sink     in_ch,
  pott_out_if.source  out_ch
);

  // Controller and datapath talk only through these two bundles.
  pott_pkg::ctrl_cmd_t cmd;
  pott_pkg::dp_stat_t  stat;

  // The controller owns the request handshake: a request is taken only when
  // the previous one has issued all its results into the result register.
  pott_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the slot flags in flops (cleared by reset and by
  // clear), the slot payload in a RAM, and the result register that decouples
  // the result side: a new request can be taken while a result still waits.
  pott_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_ch.op),
    .in_amount_us  (in_ch.amount_us),
    .in_cancel_id  (in_ch.cancel_id),
    .in_now_us     (in_ch.now_us),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_kind      (out_ch.kind),
    .out_result_id (out_ch.result_id),
    .out_ok        (out_ch.ok),
    .out_last      (out_ch.last)
  );

  // A result may only be loaded when the result register is free.
  `POTT_ASSERT(a_emit_free, clk, rst_n, cmd.emit != pott_pkg::EMIT_NONE |-> stat.out_free, "result loaded into busy register")
  // A new slot is never claimed in a full table.
  `POTT_ASSERT(a_reg_not_full, clk, rst_n, cmd.do_reg |-> !stat.full, "registration into full table")
  // Once a request is taken, the next one waits.
  `POTT_ASSERT(a_one_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready |=> !in_ch.ready, "second request taken while busy")

endmodule
